@@ rtl/core/frt_pkg.sv @@
// Package for the quarter-turn frame rotator: command and register codes,
// rotation decode types and the result metadata struct. No dependencies.
package frt_pkg;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  // decoded rotation; ok is low when the angle is not a quarter multiple
  typedef struct packed {
    logic ok;
    rot_e quarter;
  } rot_t;

  typedef struct packed {
    logic       valid;
    logic       row_end;
    logic       last;
    logic [7:0] out_width;
    logic [7:0] out_height;
  } meta_t;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_LEFT    = 8'd3;

  // angle mod 360 via reciprocal: q = (a * 11651) >> 22, exact for 16-bit a
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned ANGLE_RECIP = 11651;
  localparam int unsigned ANGLE_SHIFT = 22;
  localparam int unsigned PROD_W      = 30;
  localparam int unsigned QUOT_W      = PROD_W - ANGLE_SHIFT;
  localparam int unsigned REM_FULL_W  = 17;

  localparam logic [8:0] FULL_TURN  = 9'd360;
  localparam logic [8:0] TURN_90    = 9'd90;
  localparam logic [8:0] TURN_180   = 9'd180;
  localparam logic [8:0] TURN_270   = 9'd270;

  // settle counter value loaded on each register write, covering the angle decode
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

endpackage

@@ rtl/core/frame_rotate_quarter_turns.sv @@
// Top level of the quarter-turn frame rotator: configuration registers,
// angle settle interlock, frame store RAM. Uses frt_pkg, frt_ram,
// frt_angle and frt_seq.
//
//  channel   signals                                   direction  handshake
//  ------------------------------------------------------------------------
//  request   start_i, busy_o, command_i, pixel_in_i    in         start & !busy
//  result    out_valid_o, pixel_out_o, out_width_o,    out        strobe, 1 cycle
//            out_height_o, row_end_o, last_o
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,    in         valid & ready
//            cfg_data_i
//
// One request per clock while busy_o is low. A drain request accepted at a clock
// edge is registered first; the address is then formed from it, and the frame
// store's registered read returns the pixel alongside the registered metadata.
// After any configuration write busy_o is high while the angle decode (a
// reciprocal multiply, then a remainder stage) settles.
// rst_ni clears counters and the frame flag; the frame store is not cleared.
// The receiver cannot stall results; nothing here waits on it.
module frame_rotate_quarter_turns #(
  parameter int unsigned MAX_DIM    = 128,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               command_i,
  input  logic signed [31:0]                 pixel_in_i,
  output logic                               out_valid_o,
  output logic signed [31:0]                 pixel_out_o,
  output logic [7:0]                         out_width_o,
  output logic [7:0]                         out_height_o,
  output logic                               row_end_o,
  output logic                               last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [frt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [frt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import frt_pkg::*;

  localparam int unsigned IDX_W     = $clog2(MAX_DIM);
  localparam int unsigned RAM_DEPTH = MAX_DIM * (2 ** IDX_W);

  logic [7:0]           frame_width_q, frame_height_q;
  logic [ANGLE_W-1:0]   angle_q;
  logic                 turn_left_q;
  logic [1:0]           settle_d, settle_q;
  logic                 cfg_we, req;
  rot_t                 rot;
  meta_t                meta;

  logic                 ram_en, ram_we;
  logic [2*IDX_W-1:0]   ram_addr;
  logic [PIXEL_BITS-1:0] ram_wdata, ram_rdata;

  // config port never stalls
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 8'd1;
      frame_height_q <= 8'd1;
      angle_q        <= '0;
      turn_left_q    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[7:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[7:0];
        CFG_ANGLE:        angle_q        <= cfg_data_i;
        CFG_TURN_LEFT:    turn_left_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // hold off requests until the decoded rotation reflects the new registers
  always_comb begin
    settle_d = settle_q;
    if (cfg_we) begin
      settle_d = SETTLE_CYCLES;
    end else if (settle_q != 2'd0) begin
      settle_d = settle_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'd0;
    end else begin
      settle_q <= settle_d;
    end
  end

  assign busy_o = (settle_q != 2'd0);
  assign req    = start_i && !busy_o;

  frt_angle u_angle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .angle_i     (angle_q),
    .turn_left_i (turn_left_q),
    .rot_o       (rot)
  );

  frt_seq #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .command_i      (command_i),
    .pixel_i        (pixel_in_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .rot_i          (rot),
    .ram_en_o       (ram_en),
    .ram_we_o       (ram_we),
    .ram_addr_o     (ram_addr),
    .ram_wdata_o    (ram_wdata),
    .meta_o         (meta)
  );

  // frame store, addressed {row, col}
  frt_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = meta.valid;
  assign pixel_out_o  = 32'(ram_rdata);
  assign out_width_o  = meta.out_width;
  assign out_height_o = meta.out_height;
  assign row_end_o    = meta.row_end;
  assign last_o       = meta.last;

`ifndef SYNTHESIS
  a_no_cfg_in_settle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> busy_o)
    else $error("requests open right after a register write");

  a_settle_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we ##1 !cfg_we) |=> busy_o)
    else $error("settle window shorter than the angle decode");

  a_rot_stable_when_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !cfg_we) |=> $stable(rot))
    else $error("decoded rotation moved while requests were open");
`endif

endmodule

@@ rtl/core/frt_ram.sv @@
// Generic single-port RAM with registered read, used for the frame store.
// No dependencies.
module frt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/frt_angle.sv @@
// Angle decode: reduces the angle register modulo 360, applies the left
// turn and classifies the quarter. Two register stages. Uses frt_pkg.
module frt_angle (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [frt_pkg::ANGLE_W-1:0]  angle_i,
  input  logic                         turn_left_i,
  output frt_pkg::rot_t                rot_o
);
  import frt_pkg::*;

  logic [PROD_W-1:0]     prod_d, prod_q;
  logic [QUOT_W-1:0]     quot;
  logic [REM_FULL_W-1:0] rem_full;
  logic [8:0]            rem, turn;
  rot_t                  rot_d, rot_q;

  assign prod_d = PROD_W'(angle_i) * PROD_W'(ANGLE_RECIP);

  always_comb begin
    quot     = prod_q[PROD_W-1 -: QUOT_W];
    rem_full = REM_FULL_W'(angle_i) - REM_FULL_W'(quot) * REM_FULL_W'(FULL_TURN);
    rem      = rem_full[8:0];
    // left turn by d is a right turn by 360 - d; zero stays zero
    turn     = (turn_left_i && rem != 9'd0) ? (FULL_TURN - rem) : rem;
    rot_d.ok      = 1'b1;
    rot_d.quarter = ROT_0;
    if (turn == 9'd0) begin
      rot_d.quarter = ROT_0;
    end else if (turn == TURN_90) begin
      rot_d.quarter = ROT_90;
    end else if (turn == TURN_180) begin
      rot_d.quarter = ROT_180;
    end else if (turn == TURN_270) begin
      rot_d.quarter = ROT_270;
    end else begin
      rot_d.ok = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q        <= '0;
      rot_q.ok      <= 1'b1;
      rot_q.quarter <= ROT_0;
    end else begin
      prod_q <= prod_d;
      rot_q  <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

@@ rtl/core/frt_seq.sv @@
// Request sequencer: load and emit address counters, frame store access,
// result metadata. Drives the frt_ram port. Uses frt_pkg.
module frt_seq #(
  parameter int unsigned MAX_DIM    = 128,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_i,
  input  logic                              command_i,
  input  logic [31:0]                       pixel_i,
  input  logic [7:0]                        frame_width_i,
  input  logic [7:0]                        frame_height_i,
  input  frt_pkg::rot_t                     rot_i,
  output logic                              ram_en_o,
  output logic                              ram_we_o,
  output logic [2*$clog2(MAX_DIM)-1:0]      ram_addr_o,
  output logic [PIXEL_BITS-1:0]             ram_wdata_o,
  output frt_pkg::meta_t                    meta_o
);
  import frt_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_DIM);
  localparam int unsigned CMP_W = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

  logic              req_q;
  cmd_e              cmd_q;
  logic [31:0]       pix_q;
  logic [IDX_W-1:0]  load_row_d, load_row_q, load_col_d, load_col_q;
  logic [IDX_W-1:0]  emit_row_d, emit_row_q, emit_col_d, emit_col_q;
  logic              loaded_d, loaded_q;
  meta_t             meta_d, meta_q;

  logic [CMP_W-1:0]  w_eff, h_eff, ow, oh;
  logic [CMP_W-1:0]  lr, lc, er, ec, sr, sc;
  logic              col_wrap, row_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= 1'b0;
      cmd_q <= CMD_LOAD;
    end else begin
      req_q <= req_i;
      if (req_i) begin
        cmd_q <= cmd_e'(command_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      pix_q <= pixel_i;
    end
  end

  // register value 0 acts as 1, above MAX_DIM acts as MAX_DIM
  always_comb begin
    if (frame_width_i == 8'd0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(frame_width_i) > CMP_W'(MAX_DIM)) begin
      w_eff = CMP_W'(MAX_DIM);
    end else begin
      w_eff = CMP_W'(frame_width_i);
    end
    if (frame_height_i == 8'd0) begin
      h_eff = CMP_W'(1);
    end else if (CMP_W'(frame_height_i) > CMP_W'(MAX_DIM)) begin
      h_eff = CMP_W'(MAX_DIM);
    end else begin
      h_eff = CMP_W'(frame_height_i);
    end
  end

  always_comb begin
    load_row_d  = load_row_q;
    load_col_d  = load_col_q;
    emit_row_d  = emit_row_q;
    emit_col_d  = emit_col_q;
    loaded_d    = loaded_q;
    meta_d      = meta_q;
    meta_d.valid = 1'b0;
    ram_en_o    = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = '0;
    ram_wdata_o = PIXEL_BITS'(pix_q);
    col_wrap    = 1'b0;
    row_wrap    = 1'b0;
    lr = CMP_W'(load_row_q);
    lc = CMP_W'(load_col_q);
    ec = CMP_W'(emit_col_q);
    er = CMP_W'(emit_row_q);
    sr = '0;
    sc = '0;
    if (rot_i.quarter == ROT_90 || rot_i.quarter == ROT_270) begin
      ow = h_eff;
      oh = w_eff;
    end else begin
      ow = w_eff;
      oh = h_eff;
    end

    if (req_q && cmd_q == CMD_LOAD) begin
      if (lr >= h_eff || lc >= w_eff) begin
        lr = '0;
        lc = '0;
      end
      if (lr == '0 && lc == '0) begin
        loaded_d = 1'b0;
      end
      ram_en_o   = 1'b1;
      ram_we_o   = 1'b1;
      ram_addr_o = {lr[IDX_W-1:0], lc[IDX_W-1:0]};
      col_wrap   = (lc + CMP_W'(1)) >= w_eff;
      row_wrap   = (lr + CMP_W'(1)) >= h_eff;
      if (col_wrap) begin
        load_col_d = '0;
        if (row_wrap) begin
          load_row_d = '0;
          loaded_d   = 1'b1;
          emit_row_d = '0;
          emit_col_d = '0;
        end else begin
          load_row_d = IDX_W'(lr + CMP_W'(1));
        end
      end else begin
        load_row_d = lr[IDX_W-1:0];
        load_col_d = IDX_W'(lc + CMP_W'(1));
      end
    end else if (req_q && cmd_q == CMD_DRAIN && loaded_q && rot_i.ok) begin
      if (er >= oh || ec >= ow) begin
        er = '0;
        ec = '0;
      end
      unique case (rot_i.quarter)
        ROT_0: begin
          sr = er;
          sc = ec;
        end
        ROT_90: begin
          sr = h_eff - CMP_W'(1) - ec;
          sc = er;
        end
        ROT_180: begin
          sr = h_eff - CMP_W'(1) - er;
          sc = w_eff - CMP_W'(1) - ec;
        end
        ROT_270: begin
          sr = ec;
          sc = w_eff - CMP_W'(1) - er;
        end
        default: begin
          sr = er;
          sc = ec;
        end
      endcase
      ram_en_o   = 1'b1;
      ram_addr_o = {sr[IDX_W-1:0], sc[IDX_W-1:0]};
      col_wrap   = (ec + CMP_W'(1)) >= ow;
      row_wrap   = (er + CMP_W'(1)) >= oh;
      meta_d.valid      = 1'b1;
      meta_d.out_width  = 8'(ow);
      meta_d.out_height = 8'(oh);
      meta_d.row_end    = col_wrap;
      meta_d.last       = col_wrap && row_wrap;
      if (col_wrap) begin
        emit_col_d = '0;
        if (row_wrap) begin
          emit_row_d = '0;
          loaded_d   = 1'b0;
        end else begin
          emit_row_d = IDX_W'(er + CMP_W'(1));
        end
      end else begin
        emit_row_d = er[IDX_W-1:0];
        emit_col_d = IDX_W'(ec + CMP_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_row_q   <= '0;
      load_col_q   <= '0;
      emit_row_q   <= '0;
      emit_col_q   <= '0;
      loaded_q     <= 1'b0;
      meta_q       <= '0;
    end else begin
      load_row_q   <= load_row_d;
      load_col_q   <= load_col_d;
      emit_row_q   <= emit_row_d;
      emit_col_q   <= emit_col_d;
      loaded_q     <= loaded_d;
      meta_q       <= meta_d;
    end
  end

  assign meta_o = meta_q;

`ifndef SYNTHESIS
  a_result_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_q.valid |-> $past(req_q && cmd_q == CMD_DRAIN))
    else $error("result without a drain request");

  a_last_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (meta_q.valid && meta_q.last) |-> meta_q.row_end)
    else $error("last pixel not at row end");

  a_last_clears_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (meta_q.valid && meta_q.last) |-> !loaded_q)
    else $error("frame still marked loaded after last pixel");
`endif

endmodule

@@ sim/tb_frame_rotate_quarter_turns.sv @@
`timescale 1ns / 1ps
// Testbench for frame_rotate_quarter_turns: loads frames, drains them at every quarter turn
// and checks each drained pixel against a shadow copy of the rotator kept in the bench.
// Depends on frt_pkg and the block's RTL only.

module tb_frame_rotate_quarter_turns;
  import frt_pkg::*;

  localparam int unsigned MAX_DIM        = 128;
  localparam int unsigned STORE_DEPTH    = MAX_DIM * MAX_DIM;
  localparam int unsigned ITEM_TARGET    = 1800;
  localparam int unsigned CALM_TAIL      = 250;   // no random pauses for the last requests
  localparam int unsigned SETTLE_GAP     = 4;     // lets a trailing drain clear the pipeline; loads give no result
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles without any handshake or result
  localparam int unsigned REPORT_CAP     = 100;   // keep the log short on a broken build

  // one drained pixel as the block should present it
  typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  width;
    logic [7:0]  height;
    logic        row_end;
    logic        last;
  } rotated_pixel_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start_i     = 1'b0;
  logic        busy_o;
  logic        command_i   = CMD_LOAD;
  logic [31:0] pixel_in_i  = '0;
  logic        out_valid_o;
  logic [31:0] pixel_out_o;
  logic [7:0]  out_width_o;
  logic [7:0]  out_height_o;
  logic        row_end_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  frame_rotate_quarter_turns DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .pixel_out_o  (pixel_out_o),
    .out_width_o  (out_width_o),
    .out_height_o (out_height_o),
    .row_end_o    (row_end_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the rotator: register copies, counters and the frame store.
  // pixel_written tracks which store entries hold data, so that no drain is
  // ever sent that would read an entry the block has never been given.
  // ---------------------------------------------------------------------------
  logic [7:0]  reg_width  = 8'd1;
  logic [7:0]  reg_height = 8'd1;
  logic [15:0] reg_angle  = '0;
  logic        reg_left   = 1'b0;

  logic [31:0] frame_copy    [STORE_DEPTH];
  bit          pixel_written [STORE_DEPTH];
  int unsigned load_row = 0, load_col = 0, drain_row = 0, drain_col = 0;
  bit          frame_ready = 1'b0;

  rotated_pixel_t rotated_pixels_due[$];

  int unsigned useful_requests = 0;  // loads plus drains that give a pixel
  int unsigned mismatches      = 0;
  int unsigned idle_cycles     = 0;
  bit          pauses_on       = 1'b1;

  // register value 0 acts as 1, anything above MAX_DIM as MAX_DIM
  function automatic int unsigned clamp_dim(logic [7:0] value);
    if (value == 0) return 1;
    if (value > MAX_DIM) return MAX_DIM;
    return value;
  endfunction

  // angle mod 360, left turn mirrored; a left turn by a full multiple stays at 0
  function automatic rot_t decode_turn();
    int unsigned deg;
    rot_t        turn;
    deg = reg_angle % FULL_TURN;
    if (reg_left && deg != 0) deg = FULL_TURN - deg;
    turn.ok      = (deg % TURN_90) == 0;
    turn.quarter = rot_e'(2'(deg / TURN_90));
    return turn;
  endfunction

  // Where the next drain reads from, if it gives a pixel at all.
  // row/col come back already restarted when they fall outside the rotated frame.
  function automatic bit locate_pixel(output int unsigned addr, output int unsigned out_w,
                                      output int unsigned out_h, output int unsigned row,
                                      output int unsigned col);
    int unsigned w, h, src_row, src_col;
    rot_t        turn;
    w     = clamp_dim(reg_width);
    h     = clamp_dim(reg_height);
    turn  = decode_turn();
    addr  = 0;
    out_w = w;
    out_h = h;
    row   = drain_row;
    col   = drain_col;
    if (!frame_ready || !turn.ok) return 1'b0;
    if (turn.quarter == ROT_90 || turn.quarter == ROT_270) begin
      out_w = h;
      out_h = w;
    end
    if (row >= out_h || col >= out_w) begin
      row = 0;
      col = 0;
    end
    case (turn.quarter)
      ROT_0: begin
        src_row = row;
        src_col = col;
      end
      ROT_90: begin
        src_row = h - 1 - col;
        src_col = row;
      end
      ROT_180: begin
        src_row = h - 1 - row;
        src_col = w - 1 - col;
      end
      default: begin
        src_row = col;
        src_col = w - 1 - row;
      end
    endcase
    addr = src_row * MAX_DIM + src_col;
    return 1'b1;
  endfunction

  function automatic bit drain_reads_unwritten();
    int unsigned addr, out_w, out_h, row, col;
    return locate_pixel(addr, out_w, out_h, row, col) && !pixel_written[addr];
  endfunction

  // Steps the shadow by one accepted request and queues the pixel it yields.
  task automatic advance_rotator(cmd_e cmd, logic [31:0] pix);
    int unsigned    w, h, addr, out_w, out_h, row, col;
    rotated_pixel_t due;
    w = clamp_dim(reg_width);
    h = clamp_dim(reg_height);
    if (cmd == CMD_LOAD) begin
      // counters left over from larger dimensions restart the frame
      if (load_row >= h || load_col >= w) begin
        load_row = 0;
        load_col = 0;
      end
      if (load_row == 0 && load_col == 0) frame_ready = 1'b0;
      addr = load_row * MAX_DIM + load_col;
      frame_copy[addr]    = pix;
      pixel_written[addr] = 1'b1;
      useful_requests++;
      if (load_col + 1 >= w) begin
        load_col = 0;
        if (load_row + 1 >= h) begin
          load_row    = 0;
          frame_ready = 1'b1;
          drain_row   = 0;
          drain_col   = 0;
        end else begin
          load_row++;
        end
      end else begin
        load_col++;
      end
    end else if (locate_pixel(addr, out_w, out_h, row, col)) begin
      due.pixel   = frame_copy[addr];
      due.width   = 8'(out_w);
      due.height  = 8'(out_h);
      due.row_end = (col + 1 >= out_w);
      due.last    = due.row_end && (row + 1 >= out_h);
      rotated_pixels_due.push_back(due);
      useful_requests++;
      if (due.row_end) begin
        drain_col = 0;
        if (due.last) begin
          drain_row   = 0;
          frame_ready = 1'b0;
        end else begin
          drain_row = row + 1;
        end
      end else begin
        drain_row = row;
        drain_col = col + 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every strobe must match the oldest queued pixel.
  // ---------------------------------------------------------------------------
  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    rotated_pixel_t due;
    if (rst_ni && out_valid_o) begin
      if (rotated_pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: unexpected pixel, expected none, actual %h", $realtime, pixel_out_o);
      end else begin
        due = rotated_pixels_due.pop_front();
        check_field("pixel_out", due.pixel, pixel_out_o);
        check_field("out_width", due.width, out_width_o);
        check_field("out_height", due.height, out_height_o);
        check_field("row_end", due.row_end, row_end_o);
        check_field("last", due.last, last_o);
      end
    end
  end

  // Watchdog: any request, register write or result counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o) || out_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered and left on a rising edge.
  // ---------------------------------------------------------------------------

  // Lowers start, waits out every queued pixel, then a few cycles more so a
  // trailing load has also left the pipeline before a register changes.
  task automatic settle_block();
    start_i <= 1'b0;
    while (rotated_pixels_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  reg_width  = data[7:0];
      CFG_FRAME_HEIGHT: reg_height = data[7:0];
      CFG_ANGLE:        reg_angle  = data;
      CFG_TURN_LEFT:    reg_left   = data[0];
      default: ;  // unused index, ignored by the block
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(logic [15:0] width, logic [15:0] height, logic [15:0] angle,
                           logic [15:0] left);
    settle_block();
    write_reg(CFG_FRAME_WIDTH, width);
    write_reg(CFG_FRAME_HEIGHT, height);
    write_reg(CFG_ANGLE, angle);
    write_reg(CFG_TURN_LEFT, left);
  endtask

  // Sometimes lowers start for a random gap on the request side while pauses are enabled.
  task automatic maybe_pause();
    if (pauses_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // One request. A drain that would read a never-written entry goes out as a
  // load instead. start stays high when the next request follows at once.
  task automatic send_request(cmd_e cmd, logic [31:0] pix);
    if (cmd == CMD_DRAIN && drain_reads_unwritten()) cmd = CMD_LOAD;
    start_i    <= 1'b1;
    command_i  <= cmd;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (busy_o);
    advance_rotator(cmd, pix);
    maybe_pause();
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_and_drain(int unsigned loads, int unsigned drains);
    repeat (loads) send_request(CMD_LOAD, rand_pixel());
    repeat (drains) send_request(CMD_DRAIN, $urandom);
  endtask

  // mostly small, sometimes zero, above the limit or right at it; upper byte is noise
  function automatic logic [15:0] pick_dim();
    logic [7:0] dim;
    case ($urandom_range(0, 19))
      0:       dim = '0;
      1:       dim = 8'($urandom_range(MAX_DIM + 1, 255));
      2:       dim = 8'(MAX_DIM);
      default: dim = 8'($urandom_range(1, 6));
    endcase
    return {8'($urandom), dim};
  endfunction

  // mostly quarter turns plus whole turns, the rest any 16-bit angle
  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 4) != 0)
      return 16'(TURN_90 * $urandom_range(0, 3) + FULL_TURN * $urandom_range(0, 181));
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // drain before any frame, a 1x1 frame with reset registers, drain past the end
  task automatic test_drain_without_frame();
    send_request(CMD_DRAIN, $urandom);
    send_request(CMD_LOAD, 32'h8000_0000);
    send_request(CMD_DRAIN, $urandom);
    send_request(CMD_DRAIN, $urandom);
  endtask

  // width 0 acts as 1; extreme pixel values through a 90 degree turn
  task automatic test_pixel_extremes();
    configure(16'hAB00, 16'h5402, 16'(TURN_90), '0);
    send_request(CMD_LOAD, 32'h7FFF_FFFF);
    send_request(CMD_LOAD, 32'h8000_0000);
    load_and_drain(0, 2);
  endtask

  // 0 via left turn by two full turns, 90 and 180 clockwise, 270 as a left 90
  task automatic test_every_quarter_turn();
    configure(16'd2, 16'd1, 16'(2 * FULL_TURN), 16'd1);
    load_and_drain(2, 2);
    configure(16'd2, 16'd1, 16'(TURN_90), '0);
    load_and_drain(2, 2);
    configure(16'd2, 16'd1, 16'(TURN_180), '0);
    load_and_drain(2, 2);
    configure(16'd2, 16'd1, 16'(TURN_90), 16'd1);
    load_and_drain(2, 2);
  endtask

  // off-quarter angle gives nothing and does not move the drain position
  task automatic test_odd_angle();
    configure(16'd2, 16'd1, 16'd45, '0);
    load_and_drain(2, 1);
    configure(16'd2, 16'd1, 16'(TURN_90 + FULL_TURN), '0);
    load_and_drain(0, 2);
  endtask

  // a load mid-drain starts a new frame; drains give nothing until it completes
  task automatic test_reload_mid_drain();
    configure(16'd2, 16'd1, 16'(TURN_180), '0);
    load_and_drain(2, 1);
    load_and_drain(1, 1);
    load_and_drain(1, 2);
  endtask

  // shrinking the frame under a half-loaded one restarts the load counters
  task automatic test_resize_mid_frame();
    configure(16'd2, 16'd2, '0, '0);
    load_and_drain(3, 0);
    configure(16'd1, 16'd1, '0, '0);
    load_and_drain(1, 1);
  endtask

  // ---------------------------------------------------------------------------
  // Random frames: mostly complete load/drain sequences with random content,
  // some broken off early, some plain noise.
  // ---------------------------------------------------------------------------
  task automatic run_random_frame(int unsigned phase);
    int unsigned w, h, cells;
    logic [15:0] width_data, height_data;
    pauses_on = (useful_requests + CALM_TAIL < ITEM_TARGET) && ($urandom_range(0, 3) != 0);
    if (phase % 16 == 7 || phase % 16 == 15 || $urandom_range(0, 3) != 0) begin
      width_data  = pick_dim();
      height_data = pick_dim();
      // force the dimension extremes now and then, one side long, the other short
      if (phase % 16 == 7) begin
        width_data[7:0]  = 8'hFF;
        height_data[7:0] = '0;
      end else if (phase % 16 == 15) begin
        width_data[7:0]  = '0;
        height_data[7:0] = 8'(MAX_DIM);
      end
      if (clamp_dim(width_data[7:0]) * clamp_dim(height_data[7:0]) > 2 * MAX_DIM)
        height_data[7:0] = 8'($urandom_range(1, 2));
      configure(width_data, height_data, pick_angle(), 16'($urandom));
      if ($urandom_range(0, 7) == 0)
        write_reg(8'($urandom_range(CFG_TURN_LEFT + 1, 255)), 16'($urandom));
    end
    w     = clamp_dim(reg_width);
    h     = clamp_dim(reg_height);
    cells = w * h;
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(1, 12)) send_request(cmd_e'($urandom_range(0, 1)), rand_pixel());
      1: load_and_drain($urandom_range(1, cells), $urandom_range(0, cells));
      default: begin
        repeat (cells) begin
          if ($urandom_range(0, 39) == 0) send_request(CMD_DRAIN, $urandom);
          send_request(CMD_LOAD, rand_pixel());
        end
        repeat (cells + $urandom_range(0, 2)) begin
          if ($urandom_range(0, 59) == 0) send_request(CMD_LOAD, rand_pixel());
          send_request(CMD_DRAIN, $urandom);
        end
      end
    endcase
  endtask

  task automatic test_random_frames();
    int unsigned phase;
    phase = 0;
    while (useful_requests < ITEM_TARGET) begin
      run_random_frame(phase);
      phase++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_drain_without_frame();
    test_pixel_extremes();
    test_every_quarter_turn();
    test_odd_angle();
    test_reload_mid_drain();
    test_resize_mid_frame();
    test_random_frames();

    settle_block();
    if (mismatches == 0 && rotated_pixels_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
